/* hdl/rmj_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// Types and constants shared by the radar measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
package rmj_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 32;
   localparam int LATENCY     = 2 + SQRT_STAGES + 2 + DIV_STAGES + 1;
   localparam logic [16:0] MIN_RANGE_SQ_RESET = 17'd7;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drange_dpx;
      logic signed [31:0] drange_dpy;
      logic signed [31:0] dbearing_dpx;
      logic signed [31:0] dbearing_dpy;
      logic signed [31:0] drate_dpx;
      logic signed [31:0] drate_dpy;
      logic               div_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] apx;
      logic [31:0] apy;
      logic        negx;
      logic        negy;
      logic        posy;
      logic [63:0] c1;
      logic [63:0] cmag;
      logic        cneg;
      logic        err;
   } meta_type;

endpackage

/* hdl/rmj_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root, one root bit per stage, side data carried.
// ----------------------------------------------------------------------------
module rmj_sqrt (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       value,
   input  rmj_pkg::meta_type meta_i,
   output logic [31:0]       root,
   output rmj_pkg::meta_type meta_o
);

   localparam int N = rmj_pkg::SQRT_STAGES;

   logic [63:0]       rem_ff  [0:N-1];
   logic [31:0]       root_ff [0:N-1];
   rmj_pkg::meta_type meta_ff [0:N-1];
   logic [63:0]       rem_in  [0:N-1];
   logic [31:0]       root_in [0:N-1];
   logic [63:0]       prem    [0:N-1];
   logic [31:0]       proot   [0:N-1];
   logic [65:0]       inc     [0:N-1];

   always_comb begin
      for (int j = 0; j < N; j++) begin
         prem[j]  = (j == 0) ? value : rem_ff[(j == 0) ? 0 : j - 1];
         proot[j] = (j == 0) ? 32'd0 : root_ff[(j == 0) ? 0 : j - 1];
         inc[j]   = (66'(proot[j]) << (N - j)) + (66'd1 << (2 * (N - 1 - j)));
         if (66'(prem[j]) >= inc[j]) begin
            rem_in[j]  = prem[j] - inc[j][63:0];
            root_in[j] = proot[j] | (32'd1 << (N - 1 - j));
         end else begin
            rem_in[j]  = prem[j];
            root_in[j] = proot[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < N; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            meta_ff[j] <= (j == 0) ? meta_i : meta_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   assign root   = root_ff[N-1];
   assign meta_o = meta_ff[N-1];

endmodule

/* hdl/rmj_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider, one quotient bit per stage, signed saturation.
// ----------------------------------------------------------------------------
module rmj_div (
   input  logic         clock,
   input  logic         en,
   input  logic [127:0] num,
   input  logic [127:0] den,
   input  logic         neg,
   output logic [31:0]  quo
);

   localparam int N = rmj_pkg::DIV_STAGES;

   logic [127:0] rem_ff [0:N-1];
   logic [127:0] den_ff [0:N-1];
   logic [31:0]  q_ff   [0:N-1];
   logic         neg_ff [0:N-1];
   logic [127:0] rem_in [0:N-1];
   logic [31:0]  q_in   [0:N-1];
   logic [127:0] prem   [0:N-1];
   logic [127:0] pden   [0:N-1];
   logic [31:0]  pq     [0:N-1];
   logic [127:0] shd    [0:N-1];
   logic [31:0]  mag;

   always_comb begin
      for (int j = 0; j < N; j++) begin
         prem[j] = (j == 0) ? num : rem_ff[(j == 0) ? 0 : j - 1];
         pden[j] = (j == 0) ? den : den_ff[(j == 0) ? 0 : j - 1];
         pq[j]   = (j == 0) ? 32'd0 : q_ff[(j == 0) ? 0 : j - 1];
         shd[j]  = pden[j] << (N - 1 - j);
         if (prem[j] >= shd[j]) begin
            rem_in[j] = prem[j] - shd[j];
            q_in[j]   = pq[j] | (32'd1 << (N - 1 - j));
         end else begin
            rem_in[j] = prem[j];
            q_in[j]   = pq[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < N; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= pden[j];
            q_ff[j]   <= q_in[j];
            neg_ff[j] <= (j == 0) ? neg : neg_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   assign mag = q_ff[N-1];

   always_comb begin
      if (mag[31]) begin
         quo = neg_ff[N-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         quo = neg_ff[N-1] ? 32'(-mag) : mag;
      end
   end

endmodule

/* hdl/radar_measurement_jacobian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar measurement Jacobian of a constant-velocity state, Q16.16 saturating.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_data
//  rsp     | out       | rsp_valid, rsp_ready, rsp_data
//  csr     | in        | csr_valid, csr_ready, csr_data (min_range_sq)
//
//  One item enters per cycle while the result is not stalled; each item passes
//  the product and sum registers, 32 square-root stages, the partial-product
//  and wide-product registers, 32 divider stages and the output register.
//  Synchronous reset clears the valid chain and sets min_range_sq to 7.
//  A stalled result freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmj_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [16:0]      csr_data
);

   localparam int LAT = rmj_pkg::LATENCY;
   localparam int FB  = rmj_pkg::FRAC_BITS;
   localparam int ND  = rmj_pkg::DIV_STAGES;

   logic               en;
   logic [LAT-1:0]     vld_ff;
   logic [16:0]        min_range_sq_ff;

   logic [31:0]        apx, apy;
   logic [63:0]        sqx_ff, sqy_ff;
   logic signed [63:0] a_ff, b_ff;
   logic [31:0]        apx1_ff, apy1_ff;
   logic               negx1_ff, negy1_ff, posy1_ff;

   rmj_pkg::meta_type  meta_in, meta2_ff, meta_sq;
   logic [64:0]        diff;
   logic [63:0]        thr;
   logic [31:0]        r_sq;

   rmj_pkg::meta_type  meta35_ff, meta36_ff;
   logic [31:0]        r35_ff, r36_ff;
   logic [63:0]        pcl_ff, pch_ff, pyl_ff, pyh_ff, pxl_ff, pxh_ff;
   logic [95:0]        c3_ff, ny_ff, nx_ff;

   logic [127:0]       num [0:5];
   logic [127:0]       den [0:5];
   logic               neg [0:5];
   logic [31:0]        quo [0:5];
   logic               err_ff [0:ND-1];
   rmj_pkg::rsp_type   rsp_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         min_range_sq_ff <= rmj_pkg::MIN_RANGE_SQ_RESET;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
         if (csr_valid) begin
            min_range_sq_ff <= csr_data;
         end
      end
   end

   assign apx = req_data.pos_x[31] ? 32'(-req_data.pos_x) : 32'(req_data.pos_x);
   assign apy = req_data.pos_y[31] ? 32'(-req_data.pos_y) : 32'(req_data.pos_y);

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= apx * apx;
         sqy_ff   <= apy * apy;
         a_ff     <= 64'(req_data.vel_x) * 64'(req_data.pos_y);
         b_ff     <= 64'(req_data.vel_y) * 64'(req_data.pos_x);
         apx1_ff  <= apx;
         apy1_ff  <= apy;
         negx1_ff <= req_data.pos_x[31];
         negy1_ff <= req_data.pos_y[31];
         posy1_ff <= !req_data.pos_y[31] && (req_data.pos_y != 32'sd0);
      end
   end

   assign thr  = 64'(min_range_sq_ff) << FB;
   assign diff = (a_ff >= b_ff) ? 65'(a_ff) - 65'(b_ff) : 65'(b_ff) - 65'(a_ff);

   always_comb begin
      meta_in.apx  = apx1_ff;
      meta_in.apy  = apy1_ff;
      meta_in.negx = negx1_ff;
      meta_in.negy = negy1_ff;
      meta_in.posy = posy1_ff;
      meta_in.c1   = sqx_ff + sqy_ff;
      meta_in.cmag = diff[63:0];
      meta_in.cneg = a_ff < b_ff;
      meta_in.err  = (meta_in.c1 == 64'd0) || (meta_in.c1 < thr);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta2_ff <= meta_in;
      end
   end

   rmj_sqrt u_sqrt (
      .clock  (clock),
      .en     (en),
      .value  (meta2_ff.c1),
      .meta_i (meta2_ff),
      .root   (r_sq),
      .meta_o (meta_sq)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         meta35_ff <= meta_sq;
         r35_ff    <= r_sq;
         pcl_ff    <= meta_sq.c1[31:0] * r_sq;
         pch_ff    <= meta_sq.c1[63:32] * r_sq;
         pyl_ff    <= meta_sq.apy * meta_sq.cmag[31:0];
         pyh_ff    <= meta_sq.apy * meta_sq.cmag[63:32];
         pxl_ff    <= meta_sq.apx * meta_sq.cmag[31:0];
         pxh_ff    <= meta_sq.apx * meta_sq.cmag[63:32];
         meta36_ff <= meta35_ff;
         r36_ff    <= r35_ff;
         c3_ff     <= 96'(pcl_ff) + (96'(pch_ff) << 32);
         ny_ff     <= 96'(pyl_ff) + (96'(pyh_ff) << 32);
         nx_ff     <= 96'(pxl_ff) + (96'(pxh_ff) << 32);
      end
   end

   always_comb begin
      num[0] = 128'(meta36_ff.apx) << FB;
      den[0] = 128'(r36_ff);
      neg[0] = meta36_ff.negx;
      num[1] = 128'(meta36_ff.apy) << FB;
      den[1] = 128'(r36_ff);
      neg[1] = meta36_ff.negy;
      num[2] = 128'(meta36_ff.apy) << (2 * FB);
      den[2] = 128'(meta36_ff.c1);
      neg[2] = meta36_ff.posy;
      num[3] = 128'(meta36_ff.apx) << (2 * FB);
      den[3] = 128'(meta36_ff.c1);
      neg[3] = meta36_ff.negx;
      num[4] = 128'(ny_ff) << FB;
      den[4] = 128'(c3_ff);
      neg[4] = meta36_ff.negy != meta36_ff.cneg;
      num[5] = 128'(nx_ff) << FB;
      den[5] = 128'(c3_ff);
      neg[5] = meta36_ff.negx == meta36_ff.cneg;
   end

   for (genvar g = 0; g < 6; g++) begin : g_div
      rmj_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num[g]),
         .den   (den[g]),
         .neg   (neg[g]),
         .quo   (quo[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < ND; j++) begin
            err_ff[j] <= (j == 0) ? meta36_ff.err : err_ff[(j == 0) ? 0 : j - 1];
         end
         rsp_ff.drange_dpx   <= err_ff[ND-1] ? 32'sd0 : quo[0];
         rsp_ff.drange_dpy   <= err_ff[ND-1] ? 32'sd0 : quo[1];
         rsp_ff.dbearing_dpx <= err_ff[ND-1] ? 32'sd0 : quo[2];
         rsp_ff.dbearing_dpy <= err_ff[ND-1] ? 32'sd0 : quo[3];
         rsp_ff.drate_dpx    <= err_ff[ND-1] ? 32'sd0 : quo[4];
         rsp_ff.drate_dpy    <= err_ff[ND-1] ? 32'sd0 : quo[5];
         rsp_ff.div_error    <= err_ff[ND-1];
      end
   end

endmodule

/* hdl/rmj_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_checker
// Port-level checks of the radar measurement Jacobian, bound to the top level.
// ----------------------------------------------------------------------------
module rmj_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rmj_pkg::rsp_type rsp_data
);

   localparam logic signed [31:0] UNIT = 32'sd1 <<< rmj_pkg::FRAC_BITS;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_error |->
         rsp_data.drange_dpx == 0 && rsp_data.drange_dpy == 0 &&
         rsp_data.dbearing_dpx == 0 && rsp_data.dbearing_dpy == 0 &&
         rsp_data.drate_dpx == 0 && rsp_data.drate_dpy == 0)
      else $error("error item carries nonzero entries");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.div_error |->
         rsp_data.drange_dpx <= UNIT && rsp_data.drange_dpx >= -UNIT &&
         rsp_data.drange_dpy <= UNIT && rsp_data.drange_dpy >= -UNIT)
      else $error("range derivative exceeds one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown after reset");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
